// ===== rtl/fcbm_pkg.sv =====
// ----------------------------------------------------------------------------
// fcbm_pkg
// Shared constants for the block allocation table chain manager.
// ----------------------------------------------------------------------------
package fcbm_pkg;

  localparam int OPC_W  = 2;
  localparam int FIDX_W = 7;
  localparam int CNT_W  = 18;
  localparam int BLK_W  = 14;
  localparam int BOFF_W = 12;
  localparam int SEG_W  = 13;
  localparam int TOT_W  = 27;
  localparam int K_W    = 7;

  localparam logic [K_W-1:0]   MAX_RESULTS = 7'd64;
  localparam logic [TOT_W-1:0] SIZE_LIMIT  = 27'h7FF_FFFF;

  localparam logic [OPC_W-1:0] OP_READ   = 2'd0;
  localparam logic [OPC_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OPC_W-1:0] OP_DELETE = 2'd2;
  localparam logic [OPC_W-1:0] OP_SIZE   = 2'd3;

  localparam logic STAT_OK     = 1'b0;
  localparam logic STAT_NOFREE = 1'b1;

endpackage

// ===== rtl/fcbm_ram.sv =====
// ----------------------------------------------------------------------------
// fcbm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcbm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/fat_chain_block_manager.sv =====
// ----------------------------------------------------------------------------
// fat_chain_block_manager
// Allocation table chain manager: read, append, delete and size per file.
// ----------------------------------------------------------------------------
// One word in, one or more words out (at most 64, last marks the final one).
// After reset the block clears all table entries and file records in one
// pass and holds in_stall high meanwhile. Work then runs one word at a time
// through a small sequencer around the table and record RAMs: a size query
// reads the file record and an out-of-range file answers at once; read and
// delete walk the chain block by block; append writes segment by segment and
// scans the table from the lowest possibly free block for each new block,
// then links it in. Each result also waits for the output register.
// ----------------------------------------------------------------------------
module fat_chain_block_manager #(
  parameter int FAT_ENTRIES  = 16384,
  parameter int FILE_RECORDS = 128,
  parameter int BLOCK_BYTES  = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fcbm_pkg::OPC_W-1:0]   in_opcode,
  input  logic [fcbm_pkg::FIDX_W-1:0]  in_file_index,
  input  logic [fcbm_pkg::CNT_W-1:0]   in_byte_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_status,
  output logic [fcbm_pkg::BLK_W-1:0]   out_block_number,
  output logic [fcbm_pkg::BOFF_W-1:0]  out_block_offset,
  output logic [fcbm_pkg::SEG_W-1:0]   out_segment_bytes,
  output logic [fcbm_pkg::TOT_W-1:0]   out_total_bytes,
  output logic                         out_last
);
  import fcbm_pkg::*;

  localparam int AW     = $clog2(FAT_ENTRIES);
  localparam int LW     = AW + 1;
  localparam int FW     = (FILE_RECORDS > 1) ? $clog2(FILE_RECORDS) : 1;
  localparam int OW     = $clog2(BLOCK_BYTES + 1);
  localparam int FAT_W  = LW + 1;
  localparam int REC_W  = 2 * LW + OW + TOT_W;
  localparam int CLR_N  = (FAT_ENTRIES > FILE_RECORDS) ? FAT_ENTRIES : FILE_RECORDS;
  localparam int CCW    = $clog2(CLR_N);

  localparam logic [LW-1:0]  NONE_LINK = '1;
  localparam logic [LW-1:0]  FAT_LIM   = LW'(FAT_ENTRIES);
  localparam logic [OW-1:0]  BB        = OW'(BLOCK_BYTES);
  localparam logic [TOT_W-1:0] BB_T    = TOT_W'(BLOCK_BYTES);

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_REC     = 4'd2;
  localparam logic [3:0] S_RD_TOP  = 4'd3;
  localparam logic [3:0] S_RD_SEG  = 4'd4;
  localparam logic [3:0] S_AP_TOP  = 4'd5;
  localparam logic [3:0] S_SC_RD   = 4'd6;
  localparam logic [3:0] S_SC_CHK  = 4'd7;
  localparam logic [3:0] S_AP_LINK = 4'd8;
  localparam logic [3:0] S_AP_SEG  = 4'd9;
  localparam logic [3:0] S_DL_TOP  = 4'd10;
  localparam logic [3:0] S_DL_RD   = 4'd11;
  localparam logic [3:0] S_EMIT1   = 4'd12;

  // sequencer registers
  logic [3:0]       state_r, state_nxt;
  logic [OPC_W-1:0] op_r, op_nxt;
  logic [FW-1:0]    f_r, f_nxt;
  logic [TOT_W-1:0] n_r, n_nxt;
  logic [TOT_W-1:0] done_r, done_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [LW-1:0]    b_r, b_nxt;
  logic [LW-1:0]    first_r, first_nxt;
  logic [OW-1:0]    off_r, off_nxt;
  logic [TOT_W-1:0] size_r, size_nxt;
  logic             fail_r, fail_nxt;
  logic [LW-1:0]    free_r, free_nxt;
  logic [CCW-1:0]   clr_r, clr_nxt;
  logic [TOT_W-1:0] tot1_r, tot1_nxt;
  logic             stat1_r, stat1_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic [BLK_W-1:0]  out_blk_r, out_blk_nxt;
  logic [BOFF_W-1:0] out_boff_r, out_boff_nxt;
  logic [SEG_W-1:0]  out_seg_r, out_seg_nxt;
  logic [TOT_W-1:0]  out_tot_r, out_tot_nxt;
  logic              out_last_r, out_last_nxt;

  // RAM ports
  logic              fat_we;
  logic [AW-1:0]     fat_waddr, fat_raddr;
  logic [FAT_W-1:0]  fat_wdata, fat_rd;
  logic              rec_we;
  logic [FW-1:0]     rec_waddr, rec_raddr;
  logic [REC_W-1:0]  rec_wdata, rec_rd;

  // result request
  logic              emit;
  logic              e_status;
  logic [LW-1:0]     e_blk;
  logic [OW-1:0]     e_off;
  logic [OW-1:0]     e_seg;
  logic [TOT_W-1:0]  e_tot;
  logic              e_last;
  logic              out_free;

  // datapath helpers
  logic [LW-1:0]     fat_next;
  logic              fat_used;
  logic [LW-1:0]     rec_first, rec_tail;
  logic [OW-1:0]     rec_off;
  logic [TOT_W-1:0]  rec_size;
  logic [TOT_W-1:0]  rem;
  logic [TOT_W-1:0]  room;
  logic [OW-1:0]     space;
  logic [OW-1:0]     seg_rd, seg_ap;
  logic              in_acc;

  assign fat_used  = fat_rd[LW];
  assign fat_next  = fat_rd[LW-1:0];
  assign rec_first = rec_rd[REC_W-1 -: LW];
  assign rec_tail  = rec_rd[REC_W-LW-1 -: LW];
  assign rec_off   = rec_rd[TOT_W+OW-1 -: OW];
  assign rec_size  = rec_rd[TOT_W-1:0];

  assign rem    = n_r - done_r;
  assign room   = SIZE_LIMIT - rec_size;
  assign space  = BB - off_r;
  assign seg_rd = (rem > BB_T) ? BB : rem[OW-1:0];
  assign seg_ap = (rem > TOT_W'(space)) ? space : rem[OW-1:0];

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  fcbm_ram #(.WIDTH(FAT_W), .DEPTH(FAT_ENTRIES)) u_fat (
    .clk     (clk),
    .wr_en   (fat_we),
    .wr_addr (fat_waddr),
    .wr_data (fat_wdata),
    .rd_addr (fat_raddr),
    .rd_data (fat_rd)
  );

  fcbm_ram #(.WIDTH(REC_W), .DEPTH(FILE_RECORDS)) u_rec (
    .clk     (clk),
    .wr_en   (rec_we),
    .wr_addr (rec_waddr),
    .wr_data (rec_wdata),
    .rd_addr (rec_raddr),
    .rd_data (rec_rd)
  );

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    f_nxt     = f_r;
    n_nxt     = n_r;
    done_nxt  = done_r;
    k_nxt     = k_r;
    b_nxt     = b_r;
    first_nxt = first_r;
    off_nxt   = off_r;
    size_nxt  = size_r;
    fail_nxt  = fail_r;
    free_nxt  = free_r;
    clr_nxt   = clr_r;
    tot1_nxt  = tot1_r;
    stat1_nxt = stat1_r;

    fat_we    = 1'b0;
    fat_waddr = b_r[AW-1:0];
    fat_wdata = {1'b0, NONE_LINK};
    fat_raddr = b_r[AW-1:0];
    rec_we    = 1'b0;
    rec_waddr = f_r;
    rec_wdata = {NONE_LINK, NONE_LINK, {OW{1'b0}}, {TOT_W{1'b0}}};
    rec_raddr = f_r;

    emit     = 1'b0;
    e_status = STAT_OK;
    e_blk    = '0;
    e_off    = '0;
    e_seg    = '0;
    e_tot    = '0;
    e_last   = 1'b0;

    case (state_r)
      S_CLR: begin
        fat_we    = (32'(clr_r) < FAT_ENTRIES);
        fat_waddr = clr_r[AW-1:0];
        rec_we    = (32'(clr_r) < FILE_RECORDS);
        rec_waddr = clr_r[FW-1:0];
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == CCW'(CLR_N - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        rec_raddr = in_file_index[FW-1:0];
        if (in_acc) begin
          op_nxt   = in_opcode;
          f_nxt    = in_file_index[FW-1:0];
          n_nxt    = TOT_W'(in_byte_count);
          done_nxt = '0;
          k_nxt    = '0;
          fail_nxt = 1'b0;
          if (32'(in_file_index) >= FILE_RECORDS) begin
            tot1_nxt  = '0;
            stat1_nxt = STAT_OK;
            state_nxt = S_EMIT1;
          end else begin
            state_nxt = S_REC;
          end
        end
      end
      S_REC: begin
        first_nxt = rec_first;
        size_nxt  = rec_size;
        off_nxt   = rec_off;
        case (op_r)
          OP_READ: begin
            if (n_r > rec_size) n_nxt = rec_size;
            b_nxt     = rec_first;
            state_nxt = S_RD_TOP;
          end
          OP_APPEND: begin
            if (n_r > room) n_nxt = room;
            b_nxt     = rec_tail;
            state_nxt = S_AP_TOP;
          end
          OP_DELETE: begin
            b_nxt     = rec_first;
            state_nxt = S_DL_TOP;
          end
          default: begin
            tot1_nxt  = rec_size;
            stat1_nxt = STAT_OK;
            state_nxt = S_EMIT1;
          end
        endcase
      end
      S_RD_TOP: begin
        if (done_r < n_r && k_r < MAX_RESULTS && b_r < FAT_LIM) begin
          state_nxt = S_RD_SEG;
        end else if (k_r == '0) begin
          tot1_nxt  = '0;
          stat1_nxt = STAT_OK;
          state_nxt = S_EMIT1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_RD_SEG: begin
        emit   = 1'b1;
        e_blk  = b_r;
        e_seg  = seg_rd;
        e_tot  = done_r + TOT_W'(seg_rd);
        e_last = (done_r + TOT_W'(seg_rd) >= n_r) || (k_r == MAX_RESULTS - 1'b1)
                 || !(fat_next < FAT_LIM);
        if (out_free) begin
          done_nxt  = done_r + TOT_W'(seg_rd);
          k_nxt     = k_r + 1'b1;
          b_nxt     = fat_next;
          state_nxt = S_RD_TOP;
        end
      end
      S_AP_TOP: begin
        if (!fail_r && done_r < n_r && k_r < MAX_RESULTS) begin
          if (!(b_r < FAT_LIM) || off_r == '0 || off_r >= BB) begin
            state_nxt = S_SC_RD;
          end else begin
            state_nxt = S_AP_SEG;
          end
        end else begin
          rec_we    = 1'b1;
          rec_wdata = {first_r, b_r, (off_r >= BB) ? {OW{1'b0}} : off_r,
                       size_r + done_r};
          if (fail_r) begin
            tot1_nxt  = done_r;
            stat1_nxt = STAT_NOFREE;
            state_nxt = S_EMIT1;
          end else if (k_r == '0) begin
            tot1_nxt  = '0;
            stat1_nxt = STAT_OK;
            state_nxt = S_EMIT1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SC_RD: begin
        // everything below free_r is known to be in use
        fat_raddr = free_r[AW-1:0];
        if (free_r >= FAT_LIM) begin
          fail_nxt  = 1'b1;
          state_nxt = S_AP_TOP;
        end else begin
          state_nxt = S_SC_CHK;
        end
      end
      S_SC_CHK: begin
        free_nxt = free_r + 1'b1;
        if (fat_used) begin
          state_nxt = S_SC_RD;
        end else begin
          fat_we    = 1'b1;
          fat_waddr = free_r[AW-1:0];
          fat_wdata = {1'b1, NONE_LINK};
          if (b_r < FAT_LIM) begin
            state_nxt = S_AP_LINK;
          end else begin
            first_nxt = free_r;
            b_nxt     = free_r;
            off_nxt   = '0;
            state_nxt = S_AP_SEG;
          end
        end
      end
      S_AP_LINK: begin
        // free_r already points past the new block
        fat_we    = 1'b1;
        fat_wdata = {1'b1, free_r - 1'b1};
        b_nxt     = free_r - 1'b1;
        off_nxt   = '0;
        state_nxt = S_AP_SEG;
      end
      S_AP_SEG: begin
        emit   = 1'b1;
        e_blk  = b_r;
        e_off  = off_r;
        e_seg  = seg_ap;
        e_tot  = done_r + TOT_W'(seg_ap);
        e_last = (done_r + TOT_W'(seg_ap) >= n_r) || (k_r == MAX_RESULTS - 1'b1);
        if (out_free) begin
          done_nxt  = done_r + TOT_W'(seg_ap);
          off_nxt   = off_r + seg_ap;
          k_nxt     = k_r + 1'b1;
          state_nxt = S_AP_TOP;
        end
      end
      S_DL_TOP: begin
        if (b_r < FAT_LIM) begin
          state_nxt = S_DL_RD;
        end else begin
          rec_we    = 1'b1;
          tot1_nxt  = '0;
          stat1_nxt = STAT_OK;
          state_nxt = S_EMIT1;
        end
      end
      S_DL_RD: begin
        fat_we = 1'b1;
        if (b_r < free_r) free_nxt = b_r;
        b_nxt     = fat_next;
        state_nxt = S_DL_TOP;
      end
      S_EMIT1: begin
        emit     = 1'b1;
        e_status = stat1_r;
        e_tot    = tot1_r;
        e_last   = 1'b1;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_blk_nxt    = out_blk_r;
    out_boff_nxt   = out_boff_r;
    out_seg_nxt    = out_seg_r;
    out_tot_nxt    = out_tot_r;
    out_last_nxt   = out_last_r;
    if (emit && out_free) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = e_status;
      out_blk_nxt    = BLK_W'(e_blk);
      out_boff_nxt   = BOFF_W'(e_off);
      out_seg_nxt    = SEG_W'(e_seg);
      out_tot_nxt    = e_tot;
      out_last_nxt   = e_last;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
      fail_r      <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
      fail_r      <= fail_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    f_r          <= f_nxt;
    n_r          <= n_nxt;
    done_r       <= done_nxt;
    b_r          <= b_nxt;
    first_r      <= first_nxt;
    off_r        <= off_nxt;
    size_r       <= size_nxt;
    tot1_r       <= tot1_nxt;
    stat1_r      <= stat1_nxt;
    out_status_r <= out_status_nxt;
    out_blk_r    <= out_blk_nxt;
    out_boff_r   <= out_boff_nxt;
    out_seg_r    <= out_seg_nxt;
    out_tot_r    <= out_tot_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_number  = out_blk_r;
  assign out_block_offset  = out_boff_r;
  assign out_segment_bytes = out_seg_r;
  assign out_total_bytes   = out_tot_r;
  assign out_last          = out_last_r;

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLR && state_r != S_IDLE) |-> k_r <= MAX_RESULTS)
    else $error("result count past limit");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= FAT_LIM)
    else $error("free pointer past table end");

  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD_TOP || state_r == S_AP_TOP) |-> done_r <= n_r)
    else $error("bytes done exceed request");

  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !out_free) |=> (state_r == $past(state_r)))
    else $error("sequencer moved while result blocked");

endmodule

// ===== verif/fat_chain_block_manager_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fat_chain_block_manager_tb
// Drives read, append, delete and size words into the chain manager and
// checks every result word against a typed answer or a model of the table,
// under varied sender idling, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module fat_chain_block_manager_tb;
  import fcbm_pkg::*;

  localparam int NBLK  = 16384;
  localparam int NFILE = 128;
  localparam int BSZ   = 4096;

  typedef struct packed {
    logic              status;
    logic [BLK_W-1:0]  blk;
    logic [BOFF_W-1:0] off;
    logic [SEG_W-1:0]  seg;
    logic [TOT_W-1:0]  tot;
    logic              last;
  } seg_word_t;

  typedef struct {
    logic [OPC_W-1:0]  op;
    logic [FIDX_W-1:0] fi;
    logic [CNT_W-1:0]  cnt;
    int                tot;   // typed single-word total answer, -1 when the model decides
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [OPC_W-1:0]    in_opcode;
  logic [FIDX_W-1:0]   in_file_index;
  logic [CNT_W-1:0]    in_byte_count;
  logic                out_valid;
  logic                out_stall;
  logic                out_status;
  logic [BLK_W-1:0]    out_block_number;
  logic [BOFF_W-1:0]   out_block_offset;
  logic [SEG_W-1:0]    out_segment_bytes;
  logic [TOT_W-1:0]    out_total_bytes;
  logic                out_last;

  // allocation table shadow; -1 is the none link
  bit          blk_used [NBLK];
  int          blk_next [NBLK];
  int          file_head [NFILE];
  longint      file_len [NFILE];
  int          low_free;

  seg_word_t   seg_q [$];
  int          typed_q [$];
  int          errors;
  int          snd_idle;
  int          rcv_stall;
  bit          hold_req;
  bit          hold_done;
  int          hold_cnt;

  fat_chain_block_manager DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_opcode(in_opcode), .in_file_index(in_file_index),
    .in_byte_count(in_byte_count),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_block_number(out_block_number),
    .out_block_offset(out_block_offset), .out_segment_bytes(out_segment_bytes),
    .out_total_bytes(out_total_bytes), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic seg_word_t mk(logic st, int b, int o, int s, longint t);
    seg_word_t w;
    w.status = st;
    w.blk    = b[BLK_W-1:0];
    w.off    = o[BOFF_W-1:0];
    w.seg    = s[SEG_W-1:0];
    w.tot    = t[TOT_W-1:0];
    w.last   = 1'b0;
    return w;
  endfunction

  function automatic int grab_free_block();
    int i;
    for (i = low_free; i < NBLK; i++) begin
      if (!blk_used[i]) begin
        low_free = i + 1;
        return i;
      end
    end
    low_free = NBLK;
    return -1;
  endfunction

  // computes the segment words for one operation and updates the table
  task automatic chain_op(input logic [OPC_W-1:0] op, input int f, input longint n,
                          ref seg_word_t res[$]);
    longint want, done, room, off, sg;
    int     b, tail, nb, steps, nx;
    bit     fail;
    res.delete();
    done  = 0;
    steps = 0;
    fail  = 0;
    if (f >= NFILE) begin
      res.push_back(mk(STAT_OK, 0, 0, 0, 0));
    end else if (op == OP_READ) begin
      want = (n < file_len[f]) ? n : file_len[f];
      b = file_head[f];
      while (done < want && res.size() < MAX_RESULTS && b >= 0 && steps < NBLK) begin
        sg = want - done;
        if (sg > BSZ) sg = BSZ;
        done += sg;
        res.push_back(mk(STAT_OK, b, 0, int'(sg), done));
        b = blk_next[b];
        steps++;
      end
    end else if (op == OP_APPEND) begin
      room = longint'(SIZE_LIMIT) - file_len[f];
      if (n > room) n = room;
      tail = file_head[f];
      if (tail >= 0) begin
        while (blk_next[tail] >= 0 && steps < NBLK) begin
          tail = blk_next[tail];
          steps++;
        end
      end
      off = file_len[f] % BSZ;
      while (done < n && res.size() < MAX_RESULTS) begin
        // tail block full or missing: take the lowest free block
        if (tail < 0 || off == 0 || off >= BSZ) begin
          nb = grab_free_block();
          if (nb < 0) begin
            fail = 1;
            break;
          end
          blk_used[nb] = 1;
          blk_next[nb] = -1;
          if (tail >= 0) blk_next[tail] = nb;
          else file_head[f] = nb;
          tail = nb;
          off  = 0;
        end
        sg = n - done;
        if (sg > BSZ - off) sg = BSZ - off;
        res.push_back(mk(STAT_OK, tail, int'(off), int'(sg), done + sg));
        done += sg;
        off  += sg;
      end
      file_len[f] += done;
      if (fail) res.push_back(mk(STAT_NOFREE, 0, 0, 0, done));
    end else if (op == OP_DELETE) begin
      b = file_head[f];
      while (b >= 0 && steps < NBLK) begin
        nx = blk_next[b];
        blk_used[b] = 0;
        blk_next[b] = -1;
        if (b < low_free) low_free = b;
        b = nx;
        steps++;
      end
      file_head[f] = -1;
      file_len[f]  = 0;
      res.push_back(mk(STAT_OK, 0, 0, 0, 0));
    end else begin
      res.push_back(mk(STAT_OK, 0, 0, 0, file_len[f]));
    end
    if (res.size() == 0) res.push_back(mk(STAT_OK, 0, 0, 0, 0));
    res[res.size()-1].last = 1'b1;
  endtask

  initial begin
    int i;
    for (i = 0; i < NBLK; i++) begin
      blk_used[i] = 0;
      blk_next[i] = -1;
    end
    for (i = 0; i < NFILE; i++) begin
      file_head[i] = -1;
      file_len[i]  = 0;
    end
    low_free = 0;
    errors   = 0;
  end

  // input acceptance feeds the model, output acceptance is checked
  always @(posedge clk) begin
    seg_word_t res[$];
    seg_word_t got, want;
    int        typ;
    if (rst_n && in_valid && !in_stall) begin
      typ = typed_q.pop_front();
      chain_op(in_opcode, int'(in_file_index), longint'(in_byte_count), res);
      if (typ >= 0) begin
        want = mk(STAT_OK, 0, 0, 0, typ);
        want.last = 1'b1;
        seg_q.push_back(want);
      end else begin
        foreach (res[j]) seg_q.push_back(res[j]);
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_block_number, out_block_offset, out_segment_bytes,
             out_total_bytes, out_last};
      if (seg_q.size() == 0) begin
        $display("%0t: unexpected word exp none act %h", $time, got);
        errors++;
      end else begin
        want = seg_q.pop_front();
        if (got.status !== want.status || got.blk !== want.blk ||
            got.off !== want.off || got.seg !== want.seg ||
            got.tot !== want.tot || got.last !== want.last) begin
          $display("%0t: mismatch exp st=%0d blk=%0d off=%0d seg=%0d tot=%0d last=%0d",
                   $time, want.status, want.blk, want.off, want.seg, want.tot, want.last);
          $display("%0t:          act st=%0d blk=%0d off=%0d seg=%0d tot=%0d last=%0d",
                   $time, got.status, got.blk, got.off, got.seg, got.tot, got.last);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= 3000;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall);
    end
  end

  task automatic send_word(input logic [OPC_W-1:0] op, input logic [FIDX_W-1:0] fi,
                           input logic [CNT_W-1:0] cnt, input int typ);
    while (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid      = 1'b1;
    in_opcode     = op;
    in_file_index = fi;
    in_byte_count = cnt;
    typed_q.push_back(typ);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic set_idling(input int ph);
    case (ph)
      0: begin snd_idle = 0;  rcv_stall = 0;  end
      1: begin snd_idle = 72; rcv_stall = 0;  end
      2: begin snd_idle = 0;  rcv_stall = 72; end
      default: begin snd_idle = 34; rcv_stall = 34; end
    endcase
  endtask

  dir_row_t dir_rows[] = '{
    '{OP_SIZE,   7'd0,   18'd0,      0},   // size after reset
    '{OP_READ,   7'd0,   18'd100,    0},   // read of empty file
    '{OP_DELETE, 7'd1,   18'h3FFFF,  0},   // delete of empty file
    '{OP_APPEND, 7'd0,   18'd0,      0},   // zero-byte append
    '{OP_APPEND, 7'd0,   18'd1,      -1},
    '{OP_APPEND, 7'd0,   18'd4095,   -1},  // tail block exactly full
    '{OP_APPEND, 7'd0,   18'd1,      -1},  // full tail forces a new block
    '{OP_SIZE,   7'd0,   18'd0,      4097},
    '{OP_READ,   7'd0,   18'h3FFFF,  -1},
    '{OP_READ,   7'd0,   18'd0,      0},
    '{OP_APPEND, 7'd1,   18'h3FFFF,  -1},
    '{OP_APPEND, 7'd1,   18'h3FFFF,  -1},
    '{OP_READ,   7'd1,   18'h3FFFF,  -1},  // stops after 64 segments
    '{OP_APPEND, 7'd3,   18'd4000,   -1},
    '{OP_APPEND, 7'd3,   18'h3FFFF,  -1},  // cut at 64 segments
    '{OP_SIZE,   7'd3,   18'd0,      -1},
    '{OP_DELETE, 7'd1,   18'd0,      0},
    '{OP_SIZE,   7'd1,   18'd0,      0},
    '{OP_APPEND, 7'd127, 18'd5,      -1},
    '{OP_READ,   7'd127, 18'd3,      -1},
    '{OP_SIZE,   7'd127, 18'h2AAAA,  -1},
    '{OP_DELETE, 7'd0,   18'h15555,  0},
    '{OP_READ,   7'd127, 18'h3FFFF,  -1}
  };

  initial begin
    int i, r;
    logic [OPC_W-1:0]  op;
    logic [FIDX_W-1:0] fi;
    logic [CNT_W-1:0]  cnt;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_READ;
    in_file_index = '0;
    in_byte_count = '0;
    hold_req      = 1'b0;
    hold_done     = 1'b0;
    set_idling(0);
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[j])
      send_word(dir_rows[j].op, dir_rows[j].fi, dir_rows[j].cnt, dir_rows[j].tot);

    // fill the whole table so appends run out of free blocks, then empty it
    set_idling(3);
    for (i = 0; i < 262; i++) begin
      if (i == 40) hold_req = 1'b1;   // long output hold-off backs the block up
      send_word(OP_APPEND, 7'(i % NFILE), 18'h3FFFF, -1);
    end
    send_word(OP_APPEND, 7'd5, 18'd1, -1);
    for (i = 0; i < NFILE; i++) send_word(OP_DELETE, 7'(i), 18'($urandom), -1);

    for (i = 0; i < 80; i++) begin
      if (i % 20 == 0) set_idling(i / 20);
      r  = $urandom_range(99);
      op = (r < 35) ? OP_APPEND : (r < 70) ? OP_READ : (r < 82) ? OP_DELETE : OP_SIZE;
      fi = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(15));
      r  = $urandom_range(9);
      cnt = (r == 0) ? 18'($urandom) : (r < 3) ? 18'($urandom_range(4096)) :
            18'($urandom_range(20000));
      send_word(op, fi, cnt, -1);
    end
    in_valid = 1'b0;

    while (seg_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fcbm_pkg.sv
rtl/fcbm_ram.sv
rtl/fat_chain_block_manager.sv
verif/fat_chain_block_manager_tb.sv
